@@ rtl/poc_pkg.sv @@
// poc_pkg: shared types and constants of the pixel overlay compositor
// no dependencies; imported by poc_mul, poc_mix and pixel_overlay_compositor

package poc_pkg;

  localparam int unsigned PAL_DEPTH_DEF   = 256;
  localparam int unsigned CHAN_W          = 8;
  localparam int unsigned COLOR_W         = 6;
  localparam int unsigned PAL_W           = 3 * COLOR_W;
  localparam int unsigned SUM_W           = 10;
  localparam int unsigned PROD_W          = 16;
  localparam int unsigned LUMA_SHIFT      = 7;
  localparam int unsigned BLEND_SHIFT     = 8;
  localparam int unsigned PAL_SCALE_SHIFT = 2;
  localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;

  typedef enum logic [1:0] {
    CMD_BLEND  = 2'd0,
    CMD_LUMA   = 2'd1,
    CMD_ADD    = 2'd2,
    CMD_PAL_WR = 2'd3
  } cmd_e;

  // one palette entry, red in the top bits
  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } rgb6_t;

  // stage 1 word: captured item plus precomputed luminance sum
  typedef struct packed {
    cmd_e               cmd;
    logic [CHAN_W-1:0]  db;
    logic [CHAN_W-1:0]  dg;
    logic [CHAN_W-1:0]  dr;
    logic [CHAN_W-1:0]  alpha;
    logic [COLOR_W-1:0] tb;
    logic [COLOR_W-1:0] tg;
    logic [COLOR_W-1:0] tr;
    logic [SUM_W-1:0]   sum;
    logic               pal_ok;
  } s1_t;

  // stage 2 word: products of the blend and luminance paths
  typedef struct packed {
    cmd_e               cmd;
    logic [CHAN_W-1:0]  db;
    logic [CHAN_W-1:0]  dg;
    logic [CHAN_W-1:0]  dr;
    logic [COLOR_W-1:0] tb;
    logic [COLOR_W-1:0] tg;
    logic [COLOR_W-1:0] tr;
    logic [PROD_W-1:0]  dst_b;
    logic [PROD_W-1:0]  dst_g;
    logic [PROD_W-1:0]  dst_r;
    logic [PROD_W-1:0]  src_b;
    logic [PROD_W-1:0]  src_g;
    logic [PROD_W-1:0]  src_r;
    logic [PROD_W-1:0]  lum_b;
    logic [PROD_W-1:0]  lum_g;
    logic [PROD_W-1:0]  lum_r;
  } s2_t;

  // result word
  typedef struct packed {
    logic [CHAN_W-1:0] out_b;
    logic [CHAN_W-1:0] out_g;
    logic [CHAN_W-1:0] out_r;
    logic              pixel_valid;
  } res_t;

endpackage

@@ rtl/poc_ram.sv @@
// poc_ram: generic single-write, single-read ram with registered read data
// no dependencies; holds the palette of the compositor

module poc_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/poc_mul.sv @@
// poc_mul: second pipeline stage, all per-channel multiplies
// depends on poc_pkg; fed by the capture stage and the palette read port

module poc_mul import poc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  valid_i,
  input  s1_t   s1_i,
  input  rgb6_t pal_i,
  output logic  valid_o,
  output s2_t   s2_o
);

  logic              valid_q;
  s2_t               s2_q;
  s2_t               s2_d;
  rgb6_t             pal;
  logic [CHAN_W-1:0] inv_a;
  logic [CHAN_W-1:0] src_b;
  logic [CHAN_W-1:0] src_g;
  logic [CHAN_W-1:0] src_r;

  always_comb begin
    // out-of-range entries blend as black
    pal   = s1_i.pal_ok ? pal_i : '0;
    inv_a = CHAN_MAX - s1_i.alpha;
    src_b = {pal.b, PAL_SCALE_SHIFT'(0)};
    src_g = {pal.g, PAL_SCALE_SHIFT'(0)};
    src_r = {pal.r, PAL_SCALE_SHIFT'(0)};

    s2_d.cmd   = s1_i.cmd;
    s2_d.db    = s1_i.db;
    s2_d.dg    = s1_i.dg;
    s2_d.dr    = s1_i.dr;
    s2_d.tb    = s1_i.tb;
    s2_d.tg    = s1_i.tg;
    s2_d.tr    = s1_i.tr;
    s2_d.dst_b = PROD_W'(s1_i.alpha) * PROD_W'(s1_i.db);
    s2_d.dst_g = PROD_W'(s1_i.alpha) * PROD_W'(s1_i.dg);
    s2_d.dst_r = PROD_W'(s1_i.alpha) * PROD_W'(s1_i.dr);
    s2_d.src_b = PROD_W'(inv_a) * PROD_W'(src_b);
    s2_d.src_g = PROD_W'(inv_a) * PROD_W'(src_g);
    s2_d.src_r = PROD_W'(inv_a) * PROD_W'(src_r);
    s2_d.lum_b = PROD_W'(s1_i.sum) * PROD_W'(s1_i.tb);
    s2_d.lum_g = PROD_W'(s1_i.sum) * PROD_W'(s1_i.tg);
    s2_d.lum_r = PROD_W'(s1_i.sum) * PROD_W'(s1_i.tr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = valid_q;
  assign s2_o    = s2_q;

endmodule

@@ rtl/poc_mix.sv @@
// poc_mix: third pipeline stage, shift, add and saturate into the result word
// depends on poc_pkg; its register is the output register of the block

module poc_mix import poc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic valid_i,
  input  s2_t  s2_i,
  output logic valid_o,
  output res_t res_o
);

  logic                          valid_q;
  res_t                          res_q;
  res_t                          res_d;
  logic [PROD_W:0]               bl_b;
  logic [PROD_W:0]               bl_g;
  logic [PROD_W:0]               bl_r;
  logic [CHAN_W+1:0]             lu_b;
  logic [CHAN_W+1:0]             lu_g;
  logic [CHAN_W+1:0]             lu_r;
  logic [CHAN_W+1:0]             ad_b;
  logic [CHAN_W+1:0]             ad_g;
  logic [CHAN_W+1:0]             ad_r;

  function automatic logic [CHAN_W-1:0] sat_chan(input logic [CHAN_W+1:0] v);
    sat_chan = (v > (CHAN_W+2)'(CHAN_MAX)) ? CHAN_MAX : v[CHAN_W-1:0];
  endfunction

  always_comb begin
    bl_b = (PROD_W+1)'(s2_i.dst_b) + (PROD_W+1)'(s2_i.src_b);
    bl_g = (PROD_W+1)'(s2_i.dst_g) + (PROD_W+1)'(s2_i.src_g);
    bl_r = (PROD_W+1)'(s2_i.dst_r) + (PROD_W+1)'(s2_i.src_r);
    lu_b = (CHAN_W+2)'(s2_i.db) + (CHAN_W+2)'(s2_i.lum_b >> LUMA_SHIFT);
    lu_g = (CHAN_W+2)'(s2_i.dg) + (CHAN_W+2)'(s2_i.lum_g >> LUMA_SHIFT);
    lu_r = (CHAN_W+2)'(s2_i.dr) + (CHAN_W+2)'(s2_i.lum_r >> LUMA_SHIFT);
    ad_b = (CHAN_W+2)'(s2_i.db) + (CHAN_W+2)'(s2_i.tb);
    ad_g = (CHAN_W+2)'(s2_i.dg) + (CHAN_W+2)'(s2_i.tg);
    ad_r = (CHAN_W+2)'(s2_i.dr) + (CHAN_W+2)'(s2_i.tr);

    res_d = '0;
    unique case (s2_i.cmd)
      CMD_BLEND: begin
        res_d.out_b       = bl_b[BLEND_SHIFT +: CHAN_W];
        res_d.out_g       = bl_g[BLEND_SHIFT +: CHAN_W];
        res_d.out_r       = bl_r[BLEND_SHIFT +: CHAN_W];
        res_d.pixel_valid = 1'b1;
      end
      CMD_LUMA: begin
        res_d.out_b       = sat_chan(lu_b);
        res_d.out_g       = sat_chan(lu_g);
        res_d.out_r       = sat_chan(lu_r);
        res_d.pixel_valid = 1'b1;
      end
      CMD_ADD: begin
        res_d.out_b       = sat_chan(ad_b);
        res_d.out_g       = sat_chan(ad_g);
        res_d.out_r       = sat_chan(ad_r);
        res_d.pixel_valid = 1'b1;
      end
      CMD_PAL_WR: begin
        res_d = '0;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ rtl/pixel_overlay_compositor.sv @@
// pixel_overlay_compositor: palette sprite blend, luminance, additive tint and palette write
// stages: three register stages, capture, products and mix (the output register)
// throughput: one word per cycle unless the output is blocked; every stage is
// registered and pipelined; the ram has separate read and write ports; bubbles
// are squeezed out on stalls
// reset: rst_ni async active low clears all valid bits; palette is not cleared
// depends on poc_pkg, poc_ram, poc_mul, poc_mix

module pixel_overlay_compositor import poc_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = PAL_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // dest_b, dest_g, dest_r, color_index, alpha, tint_b, tint_g, tint_r, 6 zero bits
  input  logic [63:0] s_axis_tdata,
  // cmd
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_b, out_g, out_r
  output logic [23:0] m_axis_tdata,
  // pixel_valid
  output logic [0:0]  m_axis_tuser
);

  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
  localparam logic [CHAN_W:0] DEPTH_LIM = (CHAN_W+1)'(PALETTE_DEPTH);

  // per-stage ready: a stage moves when it is empty or the next one moves
  logic  rdy1;
  logic  rdy2;
  logic  rdy3;
  logic  accept;

  logic  valid1_q;
  s1_t   s1_q;
  s1_t   s1_d;
  logic  valid2;
  s2_t   s2;
  logic  valid3;
  res_t  res;

  rgb6_t pal_wdata;
  rgb6_t pal_rdata;
  logic  pal_we;
  logic  pal_re;

  assign rdy3          = !valid3 || m_axis_tready;
  assign rdy2          = !valid2 || rdy3;
  assign rdy1          = !valid1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign accept        = s_axis_tvalid && rdy1;

  // unpack the input word, luminance sum computed ahead of the multiplies
  always_comb begin
    s1_d.cmd    = cmd_e'(s_axis_tuser);
    s1_d.db     = s_axis_tdata[7:0];
    s1_d.dg     = s_axis_tdata[15:8];
    s1_d.dr     = s_axis_tdata[23:16];
    s1_d.alpha  = s_axis_tdata[39:32];
    s1_d.tb     = s_axis_tdata[45:40];
    s1_d.tg     = s_axis_tdata[51:46];
    s1_d.tr     = s_axis_tdata[57:52];
    s1_d.sum    = SUM_W'(s1_d.db) + SUM_W'(s1_d.dg) + SUM_W'(s1_d.dr);
    // entries past the palette depth are never stored and read as black
    s1_d.pal_ok = {1'b0, s_axis_tdata[31:24]} < DEPTH_LIM;
  end

  // palette write on accept; blend read on accept lands with stage 1
  assign pal_wdata.r = s1_d.tr;
  assign pal_wdata.g = s1_d.tg;
  assign pal_wdata.b = s1_d.tb;
  assign pal_we      = accept && (s1_d.cmd == CMD_PAL_WR) && s1_d.pal_ok;
  assign pal_re      = accept && (s1_d.cmd == CMD_BLEND);

  poc_ram #(
    .WIDTH (PAL_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (s_axis_tdata[IDX_W-1+24:24]),
    .wdata_i (pal_wdata),
    .re_i    (pal_re),
    .raddr_i (s_axis_tdata[IDX_W-1+24:24]),
    .rdata_o (pal_rdata)
  );

  // stage 1: capture register, parallel to the ram read register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else if (rdy1) begin
      valid1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: products
  poc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (rdy2),
    .valid_i (valid1_q),
    .s1_i    (s1_q),
    .pal_i   (pal_rdata),
    .valid_o (valid2),
    .s2_o    (s2)
  );

  // stage 3: sums, saturation, output register
  poc_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (rdy3),
    .valid_i (valid2),
    .s2_i    (s2),
    .valid_o (valid3),
    .res_o   (res)
  );

  assign m_axis_tvalid = valid3;
  assign m_axis_tdata  = {res.out_r, res.out_g, res.out_b};
  assign m_axis_tuser  = res.pixel_valid;

endmodule

@@ rtl/poc_checker.sv @@
// poc_checker: port-level assertions for the pixel overlay compositor
// depends on the top level's port list; bound to pixel_overlay_compositor below

module poc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // a palette write result carries no color
  a_pal_wr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == 1'b0)) |-> (m_axis_tdata == '0))
    else $error("palette write result with nonzero data");

  // input stalls only when every stage is full and the output is blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while pipeline can move");

  // an output word taken frees the whole pipeline
  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |-> s_axis_tready)
    else $error("input not ready while output word taken");

  // a blocked result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result word changed");

endmodule

bind pixel_overlay_compositor poc_checker u_poc_checker (.*);
